// ===== rtl/core/pwbr_pkg.sv =====
package pwbr_pkg;

    localparam int STAMP_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int BYTE_IDX_W = 5;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [BYTE_IDX_W-1:0] MAX_FRAME_BYTES = BYTE_IDX_W'(16);

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SOF_TIME = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_ZERO_TIME = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_ONE_TIME = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PASSIVE_ZERO_TIME = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PASSIVE_ONE_TIME = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_LIMIT = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_BYTES = 3'd7;

    localparam logic [STAMP_W-1:0] RST_SOF_TIME = 16'd200;
    localparam logic [STAMP_W-1:0] RST_ACTIVE_ZERO_TIME = 16'd128;
    localparam logic [STAMP_W-1:0] RST_ACTIVE_ONE_TIME = 16'd64;
    localparam logic [STAMP_W-1:0] RST_PASSIVE_ZERO_TIME = 16'd64;
    localparam logic [STAMP_W-1:0] RST_PASSIVE_ONE_TIME = 16'd128;
    localparam logic [STAMP_W-1:0] RST_TOLERANCE = 16'd16;
    localparam logic [STAMP_W-1:0] RST_NOISE_LIMIT = 16'd8;
    localparam logic [BYTE_IDX_W-1:0] RST_FRAME_BYTES = 5'd12;

    // window test without wrap: nominal - tol <= len <= nominal + tol
    function automatic logic in_window(input logic [STAMP_W-1:0] len,
                                       input logic [STAMP_W-1:0] nominal,
                                       input logic [STAMP_W-1:0] tol);
        logic [STAMP_W:0] lo_sum;
        logic [STAMP_W:0] hi_sum;
        lo_sum = {1'b0, len} + {1'b0, tol};
        hi_sum = {1'b0, nominal} + {1'b0, tol};
        return (lo_sum >= {1'b0, nominal}) && ({1'b0, len} <= hi_sum);
    endfunction

endpackage

// ===== rtl/core/pulse_width_bus_receiver_unit.sv =====
// Pulse-width bus receiver.
// Feed one word per line edge on the s_ channel: the captured timer stamp and
// the bus level after the edge. The block measures each pulse from the
// previous stamp, merges glitches no longer than the noise limit into a slop
// sum, opens a frame on a start pulse and decodes further pulses into bits,
// LSB first. Each finished byte leaves on the m_ channel, with m_tlast set on
// the byte that completes the frame and m_tuser carrying the sticky error.
// Edges that finish no byte give no word.
// A word taken sits in the input register and its byte, if any, reaches
// m_tvalid through the result register.
// Throughput: one edge word per cycle while the result register is free or
// draining; the pulse measurement, the three window compares and the byte
// assembly are one pass of logic between the input and result registers.
// When the receiver stalls, the result register holds its byte, the input
// register holds one more word and s_tready drops until the byte is taken.
// Reset (aresetn low at a clock edge) empties both registers, clears the
// decoder state and loads the default timing registers. Write the
// configuration port only while no edge word is in flight.
module pulse_width_bus_receiver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [pwbr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pwbr_pkg::CFG_W-1:0]        cfg_wdata,
    // edge words in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pwbr_pkg::IN_TDATA_W-1:0]   s_tdata,   // edge_stamp[15:0], line_level[16]
    // bytes out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pwbr_pkg::OUT_TDATA_W-1:0]  m_tdata,   // data_byte[7:0]
    output logic                              m_tlast,   // frame_last
    output logic                              m_tuser    // error_seen
);
    import pwbr_pkg::*;

    // timing registers
    logic [STAMP_W-1:0]    sof_time_reg;
    logic [STAMP_W-1:0]    active_zero_reg;
    logic [STAMP_W-1:0]    active_one_reg;
    logic [STAMP_W-1:0]    passive_zero_reg;
    logic [STAMP_W-1:0]    passive_one_reg;
    logic [STAMP_W-1:0]    tolerance_reg;
    logic [STAMP_W-1:0]    noise_limit_reg;
    logic [BYTE_IDX_W-1:0] frame_bytes_reg;

    // input register
    logic               in_valid_reg;
    logic [STAMP_W-1:0] in_stamp_reg;
    logic               in_level_reg;

    // decoder state
    logic [STAMP_W-1:0]    last_stamp_reg, last_stamp_next;
    logic [STAMP_W-1:0]    slop_sum_reg, slop_sum_next;
    logic                  stamp_valid_reg, stamp_valid_next;
    logic                  in_frame_reg, in_frame_next;
    logic                  prev_level_reg, prev_level_next;
    logic [7:0]            shift_byte_reg, shift_byte_next;
    logic [2:0]            bit_index_reg, bit_index_next;
    logic [BYTE_IDX_W-1:0] byte_index_reg, byte_index_next;
    logic                  error_flag_reg, error_flag_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       out_err_reg, out_err_next;

    logic advance;

    // pass logic
    logic [STAMP_W-1:0]    raw_len;
    logic [STAMP_W-1:0]    pulse_len;
    logic [STAMP_W-1:0]    nom_zero;
    logic [STAMP_W-1:0]    nom_one;
    logic                  is_glitch;
    logic                  is_sof;
    logic                  hit_zero;
    logic                  hit_one;
    logic [BYTE_IDX_W-1:0] frame_limit;
    logic [BYTE_IDX_W-1:0] byte_count;
    logic [7:0]            shifted;

    // advance the pass whenever the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sof_time_reg     <= RST_SOF_TIME;
            active_zero_reg  <= RST_ACTIVE_ZERO_TIME;
            active_one_reg   <= RST_ACTIVE_ONE_TIME;
            passive_zero_reg <= RST_PASSIVE_ZERO_TIME;
            passive_one_reg  <= RST_PASSIVE_ONE_TIME;
            tolerance_reg    <= RST_TOLERANCE;
            noise_limit_reg  <= RST_NOISE_LIMIT;
            frame_bytes_reg  <= RST_FRAME_BYTES;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SOF_TIME:          sof_time_reg     <= cfg_wdata;
                REG_ACTIVE_ZERO_TIME:  active_zero_reg  <= cfg_wdata;
                REG_ACTIVE_ONE_TIME:   active_one_reg   <= cfg_wdata;
                REG_PASSIVE_ZERO_TIME: passive_zero_reg <= cfg_wdata;
                REG_PASSIVE_ONE_TIME:  passive_one_reg  <= cfg_wdata;
                REG_TOLERANCE:         tolerance_reg    <= cfg_wdata;
                REG_NOISE_LIMIT:       noise_limit_reg  <= cfg_wdata;
                REG_FRAME_BYTES:       frame_bytes_reg  <= cfg_wdata[BYTE_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: take a word whenever the slot is free or being consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_stamp_reg <= s_tdata[STAMP_W-1:0];
            in_level_reg <= s_tdata[STAMP_W];
        end
    end

    // clamp the frame length to one..MAX_FRAME_BYTES
    always_comb begin
        if (frame_bytes_reg == '0) begin
            frame_limit = BYTE_IDX_W'(1);
        end else if (frame_bytes_reg > MAX_FRAME_BYTES) begin
            frame_limit = MAX_FRAME_BYTES;
        end else begin
            frame_limit = frame_bytes_reg;
        end
    end

    assign raw_len   = in_stamp_reg - last_stamp_reg;
    assign pulse_len = raw_len + slop_sum_reg;
    assign is_glitch = raw_len <= noise_limit_reg;
    assign nom_zero  = prev_level_reg ? active_zero_reg : passive_zero_reg;
    assign nom_one   = prev_level_reg ? active_one_reg : passive_one_reg;
    assign is_sof    = in_window(pulse_len, sof_time_reg, tolerance_reg);
    assign hit_zero  = in_window(pulse_len, nom_zero, tolerance_reg);
    assign hit_one   = in_window(pulse_len, nom_one, tolerance_reg);
    assign byte_count = byte_index_reg + BYTE_IDX_W'(1);
    // zero wins where the windows overlap
    assign shifted   = {!hit_zero, shift_byte_reg[7:1]};

    always_comb begin
        last_stamp_next  = last_stamp_reg;
        slop_sum_next    = slop_sum_reg;
        stamp_valid_next = stamp_valid_reg;
        in_frame_next    = in_frame_reg;
        prev_level_next  = prev_level_reg;
        shift_byte_next  = shift_byte_reg;
        bit_index_next   = bit_index_reg;
        byte_index_next  = byte_index_reg;
        error_flag_next  = error_flag_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_err_next     = out_err_reg;

        if (advance && in_valid_reg) begin
            last_stamp_next = in_stamp_reg;
            if (!stamp_valid_reg) begin
                // first edge: record the base only
                stamp_valid_next = 1'b1;
                prev_level_next  = in_level_reg;
            end else if (is_glitch) begin
                slop_sum_next = pulse_len;
            end else begin
                slop_sum_next   = '0;
                prev_level_next = in_level_reg;
                if (is_sof) begin
                    in_frame_next   = 1'b1;
                    shift_byte_next = '0;
                    bit_index_next  = '0;
                    byte_index_next = '0;
                end else if (in_frame_reg) begin
                    if (hit_zero || hit_one) begin
                        shift_byte_next = shifted;
                        bit_index_next  = bit_index_reg + 3'd1;
                        if (bit_index_reg == 3'd7) begin
                            // byte complete: emit and check the frame length
                            shift_byte_next = '0;
                            byte_index_next = byte_count;
                            out_valid_next  = 1'b1;
                            out_byte_next   = shifted;
                            out_err_next    = error_flag_reg;
                            out_last_next   = 1'b0;
                            if (byte_count >= frame_limit) begin
                                out_last_next   = 1'b1;
                                byte_index_next = '0;
                                in_frame_next   = 1'b0;
                            end
                        end
                    end else begin
                        error_flag_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stamp_reg  <= '0;
            slop_sum_reg    <= '0;
            stamp_valid_reg <= 1'b0;
            in_frame_reg    <= 1'b0;
            prev_level_reg  <= 1'b0;
            shift_byte_reg  <= '0;
            bit_index_reg   <= '0;
            byte_index_reg  <= '0;
            error_flag_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            last_stamp_reg  <= last_stamp_next;
            slop_sum_reg    <= slop_sum_next;
            stamp_valid_reg <= stamp_valid_next;
            in_frame_reg    <= in_frame_next;
            prev_level_reg  <= prev_level_next;
            shift_byte_reg  <= shift_byte_next;
            bit_index_reg   <= bit_index_next;
            byte_index_reg  <= byte_index_next;
            error_flag_reg  <= error_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // the error flag is sticky until reset
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_flag_reg |=> error_flag_reg)
        else $error("error flag dropped without reset");

    // a frame never opens before a base stamp is held
    a_frame_needs_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        !stamp_valid_reg |-> !in_frame_reg)
        else $error("frame open with no base stamp");

    // outside a frame no partial byte is left behind
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (bit_index_reg == 3'd0) && (shift_byte_reg == 8'd0))
        else $error("partial byte outside a frame");

    // the byte count stays below the largest frame
    a_byte_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg < MAX_FRAME_BYTES)
        else $error("byte index out of range");

    // a byte marked last closes the frame
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && out_valid_next && out_last_next) |=> !in_frame_reg)
        else $error("frame still open after last byte");

endmodule

// ===== test/tb.sv =====
module tb;
    import pwbr_pkg::*;

    // Stimulus settings and idling modes
    localparam int SET_KEEP     = 0;
    localparam int SET_NOMINAL  = 1;
    localparam int SET_WIDE     = 2;
    localparam int SET_EXACT    = 3;
    localparam int SET_DEAF     = 4;
    localparam int SET_OVERLAP  = 5;
    localparam int SET_RANDOM   = 6;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    // One edge word as it sits in s_tdata, lowest bits first: stamp, then level
    typedef struct packed {
        logic               level;
        logic [STAMP_W-1:0] stamp;
    } line_edge_t;

    // One decoded byte word as it leaves on the m_ channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } rx_byte_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    pulse_width_bus_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Words waiting for the driver, and bytes the decoder model says must come out
    line_edge_t pending_edges[$];
    rx_byte_t   expected_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int queued_edges   = 0;
    int bad_count      = 0;

    // Timing registers as the decoder model sees them
    logic [15:0] cfg_sof      = RST_SOF_TIME;
    logic [15:0] cfg_act_zero = RST_ACTIVE_ZERO_TIME;
    logic [15:0] cfg_act_one  = RST_ACTIVE_ONE_TIME;
    logic [15:0] cfg_pas_zero = RST_PASSIVE_ZERO_TIME;
    logic [15:0] cfg_pas_one  = RST_PASSIVE_ONE_TIME;
    logic [15:0] cfg_tol      = RST_TOLERANCE;
    logic [15:0] cfg_noise    = RST_NOISE_LIMIT;
    logic [4:0]  cfg_frame    = RST_FRAME_BYTES;

    // Decoder model state, all cleared by the one reset at the start
    logic        have_stamp = 1'b0;
    logic [15:0] base_stamp = '0;
    logic [15:0] slop       = '0;
    logic        framing    = 1'b0;
    logic        held_level = 1'b0;
    logic [7:0]  shreg      = '0;
    logic [2:0]  bit_cnt    = '0;
    logic [4:0]  byte_cnt   = '0;
    logic        sticky_err = 1'b0;

    // Generator position on the simulated bus line
    logic [15:0] gen_stamp = 16'hFF80;
    logic        gen_level = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Length window test, done one bit wider so nominal + tolerance cannot wrap
    function automatic logic fits(input logic [15:0] len, input logic [15:0] nominal);
        return ({1'b0, len} + {1'b0, cfg_tol} >= {1'b0, nominal}) &&
               ({1'b0, len} <= {1'b0, nominal} + {1'b0, cfg_tol});
    endfunction

    // Bytes per frame after clamping: zero acts as one, anything above the maximum as the maximum
    function automatic logic [4:0] frame_limit();
        if (cfg_frame == 0)
            return 5'd1;
        if (cfg_frame > MAX_FRAME_BYTES)
            return MAX_FRAME_BYTES;
        return cfg_frame;
    endfunction

    // Run one accepted edge through the decoder model; queue a byte if one completes
    task automatic decode_edge(input logic [15:0] stamp, input logic level);
        logic [15:0] raw;
        logic [15:0] len;
        logic        got_bit;
        logic        bit_val;
        rx_byte_t    b;
        if (!have_stamp) begin
            // first edge ever: take the base stamp and level only
            have_stamp = 1'b1;
            base_stamp = stamp;
            held_level = level;
            return;
        end
        raw = stamp - base_stamp;
        base_stamp = stamp;
        if (raw <= cfg_noise) begin
            // glitch: fold into slop, keep the held level
            slop = slop + raw;
            return;
        end
        len = raw + slop;
        slop = '0;
        got_bit = 1'b0;
        bit_val = 1'b0;
        if (fits(len, cfg_sof)) begin
            // start pulse wins over everything, even mid-frame
            framing  = 1'b1;
            shreg    = '0;
            bit_cnt  = '0;
            byte_cnt = '0;
        end else if (framing) begin
            if (fits(len, held_level ? cfg_act_zero : cfg_pas_zero)) begin
                got_bit = 1'b1;
            end else if (fits(len, held_level ? cfg_act_one : cfg_pas_one)) begin
                got_bit = 1'b1;
                bit_val = 1'b1;
            end else begin
                sticky_err = 1'b1;
            end
        end
        held_level = level;
        if (!got_bit)
            return;
        shreg = {bit_val, shreg[7:1]};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt != 0)
            return;
        byte_cnt = byte_cnt + 5'd1;
        b.data = shreg;
        b.last = 1'b0;
        b.err  = sticky_err;
        shreg  = '0;
        if (byte_cnt >= frame_limit()) begin
            b.last   = 1'b1;
            byte_cnt = '0;
            framing  = 1'b0;
        end
        expected_bytes.push_back(b);
    endtask

    // Driver: hold a word until taken, then advance to the next pending one
    always @(posedge aclk) begin
        line_edge_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                decode_edge(s_tdata[15:0], s_tdata[16]);
            if (!s_tvalid || s_tready) begin
                if (pending_edges.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = pending_edges.pop_front();
                    s_tdata  <= {{(IN_TDATA_W - 17){1'b0}}, item};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each byte word taken with the oldest expected byte
    always @(posedge aclk) begin
        rx_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected byte word: data %h last %b err %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.err) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("byte mismatch: data %h/%h last %b/%b err %b/%b (want/got)",
                                 want.data, m_tdata, want.last, m_tlast, want.err, m_tuser);
                end
            end
        end
    end

    task automatic push_edge(input logic [15:0] stamp, input logic level);
        line_edge_t e;
        e.stamp = stamp;
        e.level = level;
        pending_edges.push_back(e);
        queued_edges++;
    endtask

    // Move the line on by one pulse of the given length, no glitch inserted
    task automatic advance_line(input int unsigned len, input logic level);
        gen_stamp = gen_stamp + len[15:0];
        push_edge(gen_stamp, level);
        gen_level = level;
    endtask

    // As advance_line, but now and then split the pulse with a glitch that the slop restores
    task automatic emit_pulse(input int unsigned len, input logic level);
        int unsigned g_max;
        int unsigned g;
        if (cfg_noise != 16'hFFFF && len > cfg_noise && $urandom_range(9) == 0) begin
            g_max = len - cfg_noise - 1;
            if (g_max > cfg_noise)
                g_max = cfg_noise;
            g = $urandom_range(g_max, 0);
            gen_stamp = gen_stamp + g[15:0];
            push_edge(gen_stamp, 1'($urandom_range(1)));
            len = len - g;
        end
        advance_line(len, level);
    endtask

    // Pulse length inside the window around nominal, biased towards its bounds
    function automatic int unsigned pick_len(input logic [15:0] nominal);
        int unsigned lo;
        int unsigned hi;
        int unsigned l;
        lo = (nominal > cfg_tol) ? nominal - cfg_tol : 0;
        hi = nominal + cfg_tol;
        if (hi > 65535)
            hi = 65535;
        case ($urandom_range(7))
            0: l = lo;
            1: l = hi;
            default: l = $urandom_range(hi, lo);
        endcase
        if (l <= cfg_noise && cfg_noise != 16'hFFFF)
            l = cfg_noise + 1;
        return l;
    endfunction

    // Start pulse and a frame's worth of bits; sometimes cut short or with a stray pulse
    task automatic send_frame();
        int     nbits;
        logic   b;
        nbits = frame_limit() * 8;
        if ($urandom_range(9) == 0)
            nbits = $urandom_range(nbits, 1);
        emit_pulse(pick_len(cfg_sof), ~gen_level);
        repeat (nbits) begin
            b = 1'($urandom_range(1));
            if ($urandom_range(49) == 0)
                emit_pulse($urandom_range(65535, 1), ~gen_level);
            else
                emit_pulse(pick_len(b ? (gen_level ? cfg_act_one : cfg_pas_one)
                                      : (gen_level ? cfg_act_zero : cfg_pas_zero)),
                           ($urandom_range(19) != 0) ? ~gen_level : 1'($urandom_range(1)));
        end
    endtask

    // Mostly clean frames, the rest random pulses and random stamps
    task automatic fill_phase(input int count);
        int stop;
        stop = queued_edges + count;
        while (queued_edges < stop) begin
            case ($urandom_range(9))
                0: begin
                    gen_stamp = 16'($urandom);
                    push_edge(gen_stamp, 1'($urandom_range(1)));
                end
                1: emit_pulse($urandom_range(65535, 0), 1'($urandom_range(1)));
                default: send_frame();
            endcase
        end
    endtask

    // Write one register and mirror it into the decoder model
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            REG_SOF_TIME:          cfg_sof      = value;
            REG_ACTIVE_ZERO_TIME:  cfg_act_zero = value;
            REG_ACTIVE_ONE_TIME:   cfg_act_one  = value;
            REG_PASSIVE_ZERO_TIME: cfg_pas_zero = value;
            REG_PASSIVE_ONE_TIME:  cfg_pas_one  = value;
            REG_TOLERANCE:         cfg_tol      = value;
            REG_NOISE_LIMIT:       cfg_noise    = value;
            REG_FRAME_BYTES:       cfg_frame    = value[4:0];
            default: ;
        endcase
    endtask

    task automatic write_timing(input logic [15:0] sof, input logic [15:0] az,
                                input logic [15:0] ao, input logic [15:0] pz,
                                input logic [15:0] po, input logic [15:0] tol,
                                input logic [15:0] noise, input logic [15:0] frame);
        write_reg(REG_SOF_TIME, sof);
        write_reg(REG_ACTIVE_ZERO_TIME, az);
        write_reg(REG_ACTIVE_ONE_TIME, ao);
        write_reg(REG_PASSIVE_ZERO_TIME, pz);
        write_reg(REG_PASSIVE_ONE_TIME, po);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_NOISE_LIMIT, noise);
        write_reg(REG_FRAME_BYTES, frame);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input int which);
        case (which)
            // reset timings, longest frame
            SET_NOMINAL: write_timing(RST_SOF_TIME, RST_ACTIVE_ZERO_TIME, RST_ACTIVE_ONE_TIME,
                                      RST_PASSIVE_ZERO_TIME, RST_PASSIVE_ONE_TIME,
                                      RST_TOLERANCE, RST_NOISE_LIMIT, 16'd16);
            // start window past the top of the range, active zero window below zero,
            // passive windows overlapping, no noise filter, frame count zero
            SET_WIDE: write_timing(16'hFFFF, 16'd0, 16'd300, 16'd600, 16'd900,
                                   16'd200, 16'd0, 16'd0);
            // zero tolerance; frame count written with junk above its five bits
            SET_EXACT: write_timing(16'd3000, 16'd500, 16'd1000, 16'd1500, 16'd2000,
                                    16'd0, 16'd20, 16'hFFFF);
            // every pulse a glitch: nothing can come out
            SET_DEAF: write_timing(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom),
                                   16'hFFFF, 16'hFFFF, 16'($urandom_range(31)));
            // all bit windows the same, so zero must win
            SET_OVERLAP: write_timing(16'd1000, 16'd100, 16'd100, 16'd100, 16'd100,
                                      16'd30, 16'd5, 16'd2);
            SET_RANDOM: write_timing(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom),
                                     16'($urandom_range(300)), 16'($urandom_range(40)),
                                     16'($urandom_range(16, 1)));
            default: ;
        endcase
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 86 : (mode == IDLE_BOTH) ? 21 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 86 : (mode == IDLE_BOTH) ? 21 : 0;
    endtask

    // Drain: no word pending or offered, no byte owed, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_edges.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input int which, input int mode, input int count, input int hold);
        wait_idle();
        apply_setting(which);
        set_idling(mode);
        hold_left = hold;
        fill_phase(count);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset timings, line starts just below the stamp wrap
        set_idling(IDLE_NONE);
        push_edge(gen_stamp, 1'b1);     // first edge: base stamp only
        advance_line(100, 1'b0);        // no frame yet, dropped
        advance_line(5, 1'b1);          // glitch into slop
        advance_line(0, 1'b1);          // zero-length glitch
        advance_line(179, 1'b1);        // 184 with slop: bottom of start window; stamp wraps
        advance_line(112, 1'b0);        // active zero, lower bound
        advance_line(80, 1'b1);         // passive zero, upper bound
        advance_line(80, 1'b0);         // active one, upper bound
        advance_line(144, 1'b1);        // passive one, upper bound
        advance_line(145, 1'b0);        // active, just outside: error
        advance_line(47, 1'b1);         // passive, just below: error
        advance_line(216, 1'b0);        // top of start window, restarts the frame
        repeat (8)
            advance_line(pick_len($urandom_range(1) ? (gen_level ? cfg_act_one : cfg_pas_one)
                                                    : (gen_level ? cfg_act_zero : cfg_pas_zero)),
                         ~gen_level);
        advance_line(217, ~gen_level);  // just past the start window
        advance_line(183, ~gen_level);  // just short of it
        // each phase overruns its count by about half a frame
        fill_phase(80);

        run_phase(SET_WIDE, IDLE_SENDER, 100, 0);
        run_phase(SET_EXACT, IDLE_RECEIVER, 60, 0);
        run_phase(SET_DEAF, IDLE_BOTH, 20, 0);
        run_phase(SET_OVERLAP, IDLE_BOTH, 110, 0);
        // receiver holds off while the sender keeps offering: fill the block up
        run_phase(SET_NOMINAL, IDLE_NONE, 70, 400);
        run_phase(SET_RANDOM, IDLE_SENDER, 80, 0);
        run_phase(SET_RANDOM, IDLE_RECEIVER, 80, 0);
        run_phase(SET_RANDOM, IDLE_BOTH, 60, 0);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (bad_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: a lost byte or a hung handshake ends here
    initial begin
        #2400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
